[sv/nje_pkg.sv]
// ----------------------------------------------------------------------------
// nje_pkg
// Shared types, defaults and helpers for the neighbor joining engine.
// ----------------------------------------------------------------------------
package nje_pkg;

  localparam int MAX_TAXA_DEF   = 64;
  localparam int DIST_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD2,
    ST_SUM,
    ST_SUM_DRAIN,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_DIV,
    ST_BRANCH,
    ST_UPD0,
    ST_UPD1,
    ST_UPD2,
    ST_UPD3,
    ST_NEXT
  } state_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_START = 1'b1
  } req_t;

  // Saturate a signed value to w bits, result kept sign-extended in 64 bits
  function automatic logic signed [63:0] sat64(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

[sv/neighbor_joining_engine_unit.sv]
// Operation: a load writes an entry and then its mirror; a start runs n-2
// joins, each made of matrix walks (row sums, pair scan, one read port), a
// bit-serial division and an update pass over the other active rows.
// Throughput: one item at a time; busy stays high through the update pass
// that follows the last join beat. Reset: synchronous, active low; clears
// control, flags and cluster id marks. Results are single-cycle beats on
// out_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// neighbor_joining_engine_unit
// Iterative neighbor joining over a distance matrix held in one RAM.
// ----------------------------------------------------------------------------
module neighbor_joining_engine_unit #(
  parameter int MAX_TAXA   = nje_pkg::MAX_TAXA_DEF,
  parameter int DIST_WIDTH = nje_pkg::DIST_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic signed [31:0] in_distance,
  input  logic [6:0]  in_taxa_count,
  output logic        out_valid,
  output logic [6:0]  out_first_node,
  output logic [6:0]  out_second_node,
  output logic signed [31:0] out_first_branch,
  output logic signed [31:0] out_second_branch,
  output logic [6:0]  out_new_node,
  output logic        out_last
);

  localparam int IW    = (MAX_TAXA > 1) ? $clog2(MAX_TAXA) : 1;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = DIST_WIDTH;
  localparam int RW    = DW + 8;
  localparam int NW    = RW + 1;
  localparam int QW    = RW + 2;
  localparam int BW    = (DW < 32) ? DW : 32;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TAXA - 1);

  nje_pkg::state_t state_r, state_nxt;

  // storage
  logic signed [DW-1:0] dist_mem [DEPTH];
  logic signed [RW-1:0] rs_mem   [MAX_TAXA];
  logic signed [DW-1:0] rd_data_r;
  logic signed [RW-1:0] rs_data_r;

  logic [MAX_TAXA-1:0] act_r;
  logic [6:0]          cid_mem [MAX_TAXA];
  logic [MAX_TAXA-1:0] cid_set_r;
  logic [6:0]          cid_i_r, cid_j_r;
  logic [6:0]          rem_r;
  logic [6:0]          next_id_r;
  logic [6:0]          m2;

  // walk counters
  logic [IW-1:0] i_r, j_r, k_r;

  // memory port controls
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic signed [DW-1:0] mem_wdata;
  logic [AW-1:0]        ld2_addr_r;
  logic signed [DW-1:0] ld2_val_r;

  // pipeline stage B and C
  logic          pv1_r, pv2_r;
  logic [IW-1:0] pi1_r, pj1_r, pi2_r, pj2_r;
  logic          inc2_r;
  logic signed [RW-1:0] acc_r, acc_nxt, rsi_r;
  logic signed [RW-1:0] prod_r;
  logic signed [RW:0]   rsum_r;
  logic signed [DW-1:0] d2_r;
  logic signed [RW-1:0] rsi2_r, rsj2_r;
  logic signed [RW-1:0] rsj1;

  // best pair
  logic                 found_r;
  logic signed [QW-1:0] best_r, q_c;
  logic [IW-1:0]        bi_r, bj_r;
  logic signed [DW-1:0] dij_r;
  logic signed [RW-1:0] rsib_r, rsjb_r;

  // divider
  logic [NW-1:0] dv_mag_r;
  logic [7:0]    dv_rem_r;
  logic [7:0]    dv_cnt_r;
  logic          dv_neg_r;
  logic [7:0]    rem_sh;
  logic          dv_ge;

  // update
  logic signed [DW-1:0] tmp_r, nv_r, nv_c;

  // branch math
  logic signed [NW:0]   qs;
  logic signed [NW+1:0] di_full, dj_full;
  logic signed [NW:0]   diff_c;
  logic signed [63:0]   di_sat, dj_sat, ld_sat, nv_sat;
  logic signed [DW+1:0] nv_sum;

  logic          in_range;
  logic [6:0]    n_sat;
  logic          walk_end;
  logic          inc1;

  assign m2       = rem_r - 7'd2;
  assign busy     = (state_r != nje_pkg::ST_IDLE);
  assign walk_end = (i_r == LAST_IDX) && (j_r == LAST_IDX);
  assign in_range = (32'(in_row) < 32'(MAX_TAXA)) && (32'(in_col) < 32'(MAX_TAXA));
  assign n_sat    = (32'(in_taxa_count) > 32'(MAX_TAXA)) ? 7'(MAX_TAXA) : in_taxa_count;
  assign ld_sat   = nje_pkg::sat64(64'(in_distance), DW);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nje_pkg::ST_IDLE: begin
        if (start && (in_req_type == nje_pkg::REQ_LOAD) && in_range)
          state_nxt = nje_pkg::ST_LOAD2;
        else if (start && (in_req_type == nje_pkg::REQ_START) && (in_taxa_count >= 7'd3))
          state_nxt = nje_pkg::ST_SUM;
      end
      nje_pkg::ST_LOAD2:      state_nxt = nje_pkg::ST_IDLE;
      nje_pkg::ST_SUM:        if (walk_end) state_nxt = nje_pkg::ST_SUM_DRAIN;
      nje_pkg::ST_SUM_DRAIN:  if (!pv1_r) state_nxt = nje_pkg::ST_SCAN;
      nje_pkg::ST_SCAN:       if (walk_end) state_nxt = nje_pkg::ST_SCAN_DRAIN;
      nje_pkg::ST_SCAN_DRAIN: if (!pv1_r && !pv2_r) state_nxt = nje_pkg::ST_DIV;
      nje_pkg::ST_DIV:        if (dv_cnt_r == 8'(NW)) state_nxt = nje_pkg::ST_BRANCH;
      nje_pkg::ST_BRANCH:     state_nxt = nje_pkg::ST_UPD0;
      nje_pkg::ST_UPD0: begin
        if (act_r[k_r] && (k_r != bi_r)) state_nxt = nje_pkg::ST_UPD1;
        else if (k_r == LAST_IDX)        state_nxt = nje_pkg::ST_NEXT;
      end
      nje_pkg::ST_UPD1:       state_nxt = nje_pkg::ST_UPD2;
      nje_pkg::ST_UPD2:       state_nxt = nje_pkg::ST_UPD3;
      nje_pkg::ST_UPD3: begin
        state_nxt = (k_r == LAST_IDX) ? nje_pkg::ST_NEXT : nje_pkg::ST_UPD0;
      end
      nje_pkg::ST_NEXT: begin
        state_nxt = (rem_r > 7'd3) ? nje_pkg::ST_SUM : nje_pkg::ST_IDLE;
      end
      default:                state_nxt = nje_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= nje_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // memory address and write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {in_row[IW-1:0], in_col[IW-1:0]};
    mem_wdata = ld_sat[DW-1:0];
    mem_raddr = {i_r, j_r};
    unique case (state_r)
      nje_pkg::ST_IDLE:  mem_we = start && (in_req_type == nje_pkg::REQ_LOAD) && in_range;
      nje_pkg::ST_LOAD2: begin
        mem_we    = 1'b1;
        mem_waddr = ld2_addr_r;
        mem_wdata = ld2_val_r;
      end
      nje_pkg::ST_UPD0:  mem_raddr = {bi_r, k_r};
      nje_pkg::ST_UPD1:  mem_raddr = {bj_r, k_r};
      nje_pkg::ST_UPD2: begin
        mem_we    = 1'b1;
        mem_waddr = {bi_r, k_r};
        mem_wdata = nv_c;
      end
      nje_pkg::ST_UPD3: begin
        mem_we    = 1'b1;
        mem_waddr = {k_r, bi_r};
        mem_wdata = nv_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // distance RAM and row sum RAM
  always_ff @(posedge clk) begin
    if (mem_we) dist_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= dist_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (pv1_r && (state_r == nje_pkg::ST_SUM || state_r == nje_pkg::ST_SUM_DRAIN) &&
        (pj1_r == LAST_IDX))
      rs_mem[pi1_r] <= acc_nxt;
    rs_data_r <= rs_mem[j_r];
  end

  // cluster id RAM, read at the chosen pair while the divider runs
  always_ff @(posedge clk) begin
    if (state_r == nje_pkg::ST_BRANCH) cid_mem[bi_r] <= next_id_r;
    cid_i_r <= cid_mem[bi_r];
    cid_j_r <= cid_mem[bj_r];
  end

  // stage B: accumulate row sums, form scan terms
  assign inc1    = act_r[pi1_r] && act_r[pj1_r];
  assign acc_nxt = ((pj1_r == '0) ? '0 : acc_r) +
                   ((inc1 && (pj1_r != pi1_r)) ? RW'(rd_data_r) : '0);
  assign rsj1    = rs_data_r;

  // stage C: Q value
  assign q_c = QW'(prod_r) - QW'(rsum_r);

  // divider step
  assign rem_sh = {dv_rem_r[6:0], dv_mag_r[NW-1]};
  assign dv_ge  = (rem_sh >= {1'b0, m2});
  assign diff_c = (NW+1)'(rsib_r) - (NW+1)'(rsjb_r);

  // branch lengths
  assign qs      = dv_neg_r ? (-(NW+1)'(dv_mag_r) - (NW+1)'(dv_rem_r != 8'd0))
                            : (NW+1)'(dv_mag_r);
  assign di_full = ((NW+2)'(dij_r) + (NW+2)'(qs)) >>> 1;
  assign dj_full = (NW+2)'(dij_r) - di_full;
  assign di_sat  = nje_pkg::sat64(64'(di_full), BW);
  assign dj_sat  = nje_pkg::sat64(64'(dj_full), BW);

  // merged distance
  assign nv_sum = ((DW+2)'(tmp_r) + (DW+2)'(rd_data_r) - (DW+2)'(dij_r)) >>> 1;
  assign nv_sat = nje_pkg::sat64(64'(nv_sum), DW);
  assign nv_c   = nv_sat[DW-1:0];

  // datapath and sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= '1;
      cid_set_r <= '0;
      rem_r     <= '0;
      next_id_r <= '0;
      pv1_r     <= 1'b0;
      pv2_r     <= 1'b0;
      found_r   <= 1'b0;
      out_valid <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
    end else begin
      out_valid <= (state_r == nje_pkg::ST_BRANCH);
      pv1_r     <= (state_r == nje_pkg::ST_SUM) || (state_r == nje_pkg::ST_SCAN);
      pi1_r     <= i_r;
      pj1_r     <= j_r;
      pv2_r     <= pv1_r && (state_r == nje_pkg::ST_SCAN || state_r == nje_pkg::ST_SCAN_DRAIN);
      pi2_r     <= pi1_r;
      pj2_r     <= pj1_r;
      inc2_r    <= inc1 && (pj1_r > pi1_r);
      prod_r    <= RW'($signed({1'b0, m2})) * RW'(rd_data_r);
      rsum_r    <= (RW+1)'(rsi_r) + (RW+1)'(rsj1);
      d2_r      <= rd_data_r;
      rsi2_r    <= rsi_r;
      rsj2_r    <= rsj1;

      unique case (state_r)
        // hold swapped address for the mirror write
        nje_pkg::ST_IDLE: begin
          ld2_addr_r <= {in_col[IW-1:0], in_row[IW-1:0]};
          ld2_val_r  <= ld_sat[DW-1:0];
          i_r        <= '0;
          j_r        <= '0;
          found_r    <= 1'b0;
          if (start && (in_req_type == nje_pkg::REQ_START) && (in_taxa_count >= 7'd3)) begin
            for (int c = 0; c < MAX_TAXA; c++) begin
              act_r[c] <= (32'(c) < 32'(n_sat));
            end
            cid_set_r <= '0;
            rem_r     <= n_sat;
            next_id_r <= n_sat;
          end
        end
        // advance the matrix walk
        nje_pkg::ST_SUM, nje_pkg::ST_SCAN: begin
          j_r <= (j_r == LAST_IDX) ? '0 : j_r + 1'b1;
          if (j_r == LAST_IDX) i_r <= (i_r == LAST_IDX) ? '0 : i_r + 1'b1;
        end
        // load the divider with |ri - rj|
        nje_pkg::ST_SCAN_DRAIN: begin
          dv_neg_r <= diff_c[NW];
          dv_mag_r <= diff_c[NW] ? NW'(-diff_c) : NW'(diff_c);
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
        end
        // one quotient bit per cycle
        nje_pkg::ST_DIV: begin
          if (dv_cnt_r != 8'(NW)) begin
            dv_rem_r <= dv_ge ? (rem_sh - {1'b0, m2}) : rem_sh;
            dv_mag_r <= {dv_mag_r[NW-2:0], dv_ge};
            dv_cnt_r <= dv_cnt_r + 8'd1;
          end
        end
        // emit the join and merge j into i
        nje_pkg::ST_BRANCH: begin
          out_first_node    <= cid_set_r[bi_r] ? cid_i_r : 7'(bi_r);
          out_second_node   <= cid_set_r[bj_r] ? cid_j_r : 7'(bj_r);
          out_first_branch  <= di_sat[31:0];
          out_second_branch <= dj_sat[31:0];
          out_new_node      <= next_id_r;
          out_last          <= (rem_r == 7'd3);
          act_r[bj_r]       <= 1'b0;
          cid_set_r[bi_r]   <= 1'b1;
          next_id_r         <= next_id_r + 7'd1;
          k_r               <= '0;
        end
        nje_pkg::ST_UPD0: begin
          if (!(act_r[k_r] && (k_r != bi_r)) && (k_r != LAST_IDX)) k_r <= k_r + 1'b1;
        end
        nje_pkg::ST_UPD1: tmp_r <= rd_data_r;
        nje_pkg::ST_UPD2: nv_r  <= nv_c;
        nje_pkg::ST_UPD3: begin
          if (k_r != LAST_IDX) k_r <= k_r + 1'b1;
        end
        nje_pkg::ST_NEXT: begin
          rem_r   <= rem_r - 7'd1;
          found_r <= 1'b0;
          i_r     <= '0;
          j_r     <= '0;
        end
        default: begin
        end
      endcase

      // keep the best pair seen so far, first wins on ties
      if (pv2_r && inc2_r && (!found_r || (q_c < best_r))) begin
        found_r <= 1'b1;
        best_r  <= q_c;
        bi_r    <= pi2_r;
        bj_r    <= pj2_r;
        dij_r   <= d2_r;
        rsib_r  <= rsi2_r;
        rsjb_r  <= rsj2_r;
      end
    end
  end

  // row sum bookkeeping in stage B
  always_ff @(posedge clk) begin
    if (pv1_r) acc_r <= acc_nxt;
    if (pv1_r && (pj1_r == pi1_r)) rsi_r <= rs_data_r;
  end

`ifndef ASSERT_OFF
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == nje_pkg::REQ_START)) |=>
    (busy || $past(in_taxa_count) < 7'd3))
    else $error("start not taken");
  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result beats");
`endif

endmodule
